// ----- src/pcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcw_pkg
// Shared types and constants for the PNG chunk walker with CRC-32.
// ----------------------------------------------------------------------------
package pcw_pkg;

  // Reflected CRC-32 polynomial and the all-ones seed / final XOR mask
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;
  // Chunk type "IEND"
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  // Field counts
  localparam logic [31:0] SIG_BYTES  = 32'd8;
  localparam logic [31:0] WORD_BYTES = 32'd4;

  // Parser phases
  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4,
    PH_DONE = 3'd5
  } pcw_phase_t;

  // One input transaction held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } pcw_item_t;

endpackage

// ----- src/pcw_crc8.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcw_crc8
// Bytewise update of the reflected CRC-32: folds one byte into the remainder.
// ----------------------------------------------------------------------------
module pcw_crc8 (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [31:0] crc_out
);
  import pcw_pkg::*;

  // Shift out eight bits, folding in the polynomial on each set LSB
  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = CRC_POLY ^ (c >> 1);
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

// ----- src/pcw_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcw_in_stage
// Input register: captures one byte transaction and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
module pcw_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_file_start,
  output logic               item_valid,
  output pcw_pkg::pcw_item_t item,
  input  logic               item_take
);
  import pcw_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  pcw_item_t item_r;

  // Accept when empty or when the held transaction leaves this cycle
  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Track occupancy
  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.data_byte  <= in_data_byte;
      item_r.file_start <= in_file_start;
    end
  end

endmodule

// ----- src/pcw_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcw_parser
// Chunk state machine, running CRC and result register. Consumes one byte per
// cycle unless a result stalls; loads one on a chunk's last type or data byte.
// ----------------------------------------------------------------------------
module pcw_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  pcw_pkg::pcw_item_t item,
  output logic               item_take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_chunk_length,
  output logic [31:0]        out_chunk_type,
  output logic [31:0]        out_crc_value,
  output logic               out_end_of_image
);
  import pcw_pkg::*;

  // Parser state
  pcw_phase_t  phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] typ_r, typ_nxt;
  logic [31:0] crc_r, crc_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] res_len_r, res_typ_r, res_crc_r;
  logic        res_eoi_r;

  // State as seen by the current byte (a file start restarts the parser)
  pcw_phase_t  ph_cur;
  logic [31:0] cnt_cur, len_cur, typ_cur, crc_cur;
  logic [31:0] cnt_inc;
  logic [31:0] typ_shift;
  logic [31:0] crc_step;

  // Result of the current byte
  logic        emit;
  logic [31:0] emit_typ;
  logic        emit_eoi;

  // Advance the pipeline whenever the result register can be refilled
  assign item_take = item_valid && (!out_valid_r || out_ready);

  always_comb begin
    if (item.file_start) begin
      ph_cur  = PH_SIG;
      cnt_cur = '0;
      len_cur = '0;
      typ_cur = '0;
      crc_cur = CRC_ONES;
    end else begin
      ph_cur  = phase_r;
      cnt_cur = cnt_r;
      len_cur = len_r;
      typ_cur = typ_r;
      crc_cur = crc_r;
    end
  end

  assign cnt_inc   = cnt_cur + 32'd1;
  assign typ_shift = {typ_cur[23:0], item.data_byte};

  pcw_crc8 u_crc8 (
    .crc_in  (crc_cur),
    .data_in (item.data_byte),
    .crc_out (crc_step)
  );

  // Output decode: does this byte finish a chunk
  always_comb begin
    emit     = 1'b0;
    emit_typ = typ_cur;
    unique case (ph_cur)
      PH_TYPE: begin
        emit_typ = typ_shift;
        emit     = (cnt_inc >= WORD_BYTES) && (len_cur == 32'd0);
      end
      PH_DATA: begin
        emit = (cnt_inc == len_cur);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    emit_eoi = (emit_typ == TYPE_IEND);
  end

  // Next-state logic
  always_comb begin
    phase_nxt = ph_cur;
    cnt_nxt   = cnt_cur;
    len_nxt   = len_cur;
    typ_nxt   = typ_cur;
    crc_nxt   = crc_cur;
    unique case (ph_cur)
      PH_SIG: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= SIG_BYTES) begin
          cnt_nxt   = '0;
          len_nxt   = '0;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        len_nxt = {len_cur[23:0], item.data_byte};
        cnt_nxt = cnt_inc;
        if (cnt_inc >= WORD_BYTES) begin
          cnt_nxt   = '0;
          typ_nxt   = '0;
          crc_nxt   = CRC_ONES;
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE: begin
        typ_nxt = typ_shift;
        crc_nxt = crc_step;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= WORD_BYTES) begin
          cnt_nxt   = '0;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        crc_nxt = crc_step;
        cnt_nxt = cnt_inc;
      end
      PH_CRC: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= WORD_BYTES) begin
          cnt_nxt   = '0;
          len_nxt   = '0;
          phase_nxt = PH_LEN;
        end
      end
      default: begin
        phase_nxt = ph_cur;
      end
    endcase
    // Chunk finished: drop to the stored CRC, or stop after IEND
    if (emit) begin
      cnt_nxt   = '0;
      phase_nxt = emit_eoi ? PH_DONE : PH_CRC;
    end
  end

  // Result register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (item_take) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIG;
      cnt_r       <= '0;
      len_r       <= '0;
      typ_r       <= '0;
      crc_r       <= CRC_ONES;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (item_take) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        len_r   <= len_nxt;
        typ_r   <= typ_nxt;
        crc_r   <= crc_nxt;
      end
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      res_len_r <= len_cur;
      res_typ_r <= emit_typ;
      res_crc_r <= crc_step ^ CRC_ONES;
      res_eoi_r <= emit_eoi;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chunk_length = res_len_r;
  assign out_chunk_type   = res_typ_r;
  assign out_crc_value    = res_crc_r;
  assign out_end_of_image = res_eoi_r;

  // Signature count stays below eight bytes
  a_sig_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SIG) |-> (cnt_r < SIG_BYTES))
    else $error("signature byte count out of range");

  // Length, type and stored CRC counts stay below four bytes
  a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LEN || phase_r == PH_TYPE || phase_r == PH_CRC)
      |-> (cnt_r < WORD_BYTES))
    else $error("field byte count out of range");

  // A result comes only from a type or data byte
  a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (ph_cur == PH_TYPE || ph_cur == PH_DATA))
    else $error("result outside type or data phase");

  // An IEND result leaves the parser done
  a_iend_done: assert property (@(posedge clk) disable iff (!rst_n)
    (item_take && emit && emit_eoi) |=> (phase_r == PH_DONE && out_valid_r && res_eoi_r))
    else $error("IEND did not end the file");

  // A stalled result is not overwritten
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(res_crc_r) && $stable(res_len_r)))
    else $error("stalled result changed");

endmodule

// ----- src/png_chunk_walker_crc32.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_chunk_walker_crc32
// Walks the chunks of a PNG byte stream and reports each chunk's length, type
// and CRC-32 over type and data.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one file byte per transaction;
//   in_file_start marks the first signature byte of a new file and restarts
//   the parser. No file_start is needed for the first file after reset.
//   Output channel (out_valid/out_ready) carries one transaction per chunk,
//   loaded when the last data byte arrives (the last type byte for an empty
//   chunk). Stored CRC bytes are skipped, not checked. After IEND the block
//   sets out_end_of_image and ignores bytes until the next file start.
//   Throughput: one byte per cycle while no result stalls; the bytewise CRC
//   update between input register and result register is combinational.
//   Output path: a chunk's last byte is held in the input register, then
//   loads the result register, which drives out_valid.
//   Reset: synchronous, active low; the parser waits for a signature and
//   both registers empty.
//   Stall: while out_ready is low a result holds; the input register takes
//   at most one more byte, then in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module png_chunk_walker_crc32 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_file_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_chunk_length,
  output logic [31:0] out_chunk_type,
  output logic [31:0] out_crc_value,
  output logic        out_end_of_image
);
  import pcw_pkg::*;

  logic      item_valid;
  logic      item_take;
  pcw_item_t item;

  // Register the incoming byte
  pcw_in_stage u_in_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_file_start (in_file_start),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take)
  );

  // Parse, update CRC and hold the result
  pcw_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item_valid),
    .item             (item),
    .item_take        (item_take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_chunk_length (out_chunk_length),
    .out_chunk_type   (out_chunk_type),
    .out_crc_value    (out_crc_value),
    .out_end_of_image (out_end_of_image)
  );

endmodule

// ----- tb/sv/png_chunk_walker_crc32_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_chunk_walker_crc32_tb
// Self-checking bench for the PNG chunk walker with CRC-32.
// A short stimulus table covers the stream before any file start, an empty
// IEND chunk with its well-known CRC, bytes after the end and a restart.
// Random PNG-like files follow: mostly well-formed chunk sequences, plus
// truncated files, runaway lengths and spliced starts. A chunk predictor
// tracks the parser and each out transaction is checked field by field.
// Both channels idle in short random bursts; the receiver holds off once
// for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module png_chunk_walker_crc32_tb;
  import pcw_pkg::*;

  localparam int          ITEM_TARGET = 1350;
  localparam int          CALM_ITEMS  = 150;
  localparam int          LONG_HOLD   = 100;
  localparam int          DRAIN_WAIT  = 10;
  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [63:0] PNG_SIG     = 64'h8950_4E47_0D0A_1A0A;

  typedef struct packed {
    logic [31:0] length;
    logic [31:0] ctype;
    logic [31:0] crc;
    logic        eoi;
  } chunk_res_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
    logic       typed;
    chunk_res_t res;
  } stim_row_t;

  typedef enum int {FILE_CLEAN, FILE_CUT, FILE_HUGE, FILE_SPLICED} file_kind_t;

  localparam chunk_res_t NO_RES     = '0;
  localparam chunk_res_t IEND_EMPTY = '{32'd0, TYPE_IEND, 32'hAE42_6082, 1'b1};

  // Stream without file start, empty IEND, a byte after the end, restart
  localparam stim_row_t STIM_TAB [25] = '{
    '{8'h89, 1'b0, 1'b0, NO_RES}, '{8'h50, 1'b0, 1'b0, NO_RES},
    '{8'h4E, 1'b0, 1'b0, NO_RES}, '{8'h47, 1'b0, 1'b0, NO_RES},
    '{8'h0D, 1'b0, 1'b0, NO_RES}, '{8'h0A, 1'b0, 1'b0, NO_RES},
    '{8'h1A, 1'b0, 1'b0, NO_RES}, '{8'h0A, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h49, 1'b0, 1'b0, NO_RES}, '{8'h45, 1'b0, 1'b0, NO_RES},
    '{8'h4E, 1'b0, 1'b0, NO_RES}, '{8'h44, 1'b0, 1'b1, IEND_EMPTY},
    '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b1, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'hA5, 1'b0, 1'b0, NO_RES},
    '{8'h5A, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_file_start;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_chunk_length;
  logic [31:0] out_chunk_type;
  logic [31:0] out_crc_value;
  logic        out_end_of_image;

  // Chunk predictor state
  pcw_phase_t  pr_phase  = PH_SIG;
  logic [31:0] pr_count  = '0;
  logic [31:0] pr_length = '0;
  logic [31:0] pr_type   = '0;
  logic [31:0] pr_crc    = CRC_ONES;

  chunk_res_t  chunk_q[$];
  pcw_item_t   file_q[$];
  int          err_count     = 0;
  int          cycle_cnt     = 0;
  bit          idle_on       = 1'b0;
  bit          quiet         = 1'b0;
  bit          long_hold_req = 1'b0;

  png_chunk_walker_crc32 i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_file_start    (in_file_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_chunk_length (out_chunk_length),
    .out_chunk_type   (out_chunk_type),
    .out_crc_value    (out_crc_value),
    .out_end_of_image (out_end_of_image)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bytewise reflected CRC-32 update
  function automatic logic [31:0] crc32_step(logic [31:0] c_in, logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // Advance the chunk predictor by one byte; return 1 when a chunk closes
  function automatic bit walk_byte(logic [7:0] b, logic fs, output chunk_res_t res);
    bit close_chunk;
    close_chunk = 1'b0;
    res = '0;
    if (fs) begin
      pr_phase  = PH_SIG;
      pr_count  = '0;
      pr_length = '0;
      pr_type   = '0;
      pr_crc    = CRC_ONES;
    end
    case (pr_phase)
      PH_SIG: begin
        pr_count++;
        if (pr_count >= SIG_BYTES) begin
          pr_count  = '0;
          pr_length = '0;
          pr_phase  = PH_LEN;
        end
      end
      PH_LEN: begin
        pr_length = {pr_length[23:0], b};
        pr_count++;
        if (pr_count >= WORD_BYTES) begin
          pr_count = '0;
          pr_type  = '0;
          pr_crc   = CRC_ONES;
          pr_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        pr_type = {pr_type[23:0], b};
        pr_crc  = crc32_step(pr_crc, b);
        pr_count++;
        if (pr_count >= WORD_BYTES) begin
          pr_count = '0;
          if (pr_length == 32'd0) close_chunk = 1'b1;
          else pr_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        pr_crc = crc32_step(pr_crc, b);
        pr_count++;
        if (pr_count == pr_length) close_chunk = 1'b1;
      end
      PH_CRC: begin
        pr_count++;
        if (pr_count >= WORD_BYTES) begin
          pr_count  = '0;
          pr_length = '0;
          pr_phase  = PH_LEN;
        end
      end
      default: ;
    endcase
    // Close the chunk: emit it and skip the stored CRC, or stop after IEND
    if (close_chunk) begin
      res      = '{pr_length, pr_type, ~pr_crc, pr_type == TYPE_IEND};
      pr_count = '0;
      pr_phase = (pr_type == TYPE_IEND) ? PH_DONE : PH_CRC;
    end
    return close_chunk;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH @%0t %s: got %08h, expected %08h", $realtime, what, got, want);
    err_count++;
  endtask

  // Offer one byte, hold it until accepted, then predict
  task automatic send_byte(logic [7:0] b, logic fs, logic typed, chunk_res_t typed_res);
    chunk_res_t res;
    bit         hit;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_file_start <= fs;
    do @(posedge clk); while (!in_ready);
    hit = walk_byte(b, fs, res);
    if (typed) chunk_q.push_back(typed_res);
    else if (hit) chunk_q.push_back(res);
  endtask

  task automatic add_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_q.push_back('{w[8*i +: 8], 1'b0});
  endtask

  // Append a chunk: length, type, data bytes, stored CRC
  task automatic add_chunk(logic [31:0] len, logic [31:0] ctype, logic [31:0] crc);
    add_word(len);
    add_word(ctype);
    for (int i = 0; i < int'(len); i++) file_q.push_back('{8'($urandom), 1'b0});
    add_word(crc);
  endtask

  // Build one file into file_q; counted excludes trailing bytes after IEND
  task automatic build_file(file_kind_t kind, output int counted);
    bit          real_sig;
    int          n_chunks;
    int          len;
    int          pick;
    int          cut;
    logic [31:0] ctype;
    file_q.delete();
    real_sig = $urandom_range(0, 9) < 7;
    for (int i = 0; i < 8; i++) begin
      file_q.push_back('{real_sig ? PNG_SIG[63 - 8*i -: 8] : 8'($urandom),
                         (i == 0) && (kind != FILE_SPLICED)});
    end
    n_chunks = $urandom_range(1, 4);
    for (int c = 0; c < n_chunks; c++) begin
      pick = $urandom_range(0, 9);
      len  = (pick < 5) ? $urandom_range(0, 4) :
             (pick < 9) ? $urandom_range(5, 24) : $urandom_range(25, 80);
      for (int i = 0; i < 4; i++) begin
        ctype = {ctype[23:0], ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                 8'(8'h41 + $urandom_range(0, 25)) | ($urandom_range(0, 1) ? 8'h20 : 8'h00)};
      end
      add_chunk(32'(len), ctype, $urandom);
    end
    if (kind == FILE_HUGE) begin
      // Runaway length: a few data bytes, then a next file with a file start cuts it off
      add_word($urandom_range(0, 1) ? 32'hFFFF_FFFF : {1'b1, 31'($urandom)});
      add_word($urandom);
      repeat ($urandom_range(0, 6)) file_q.push_back('{8'($urandom), 1'b0});
      counted = file_q.size();
    end else begin
      add_chunk(32'd0, TYPE_IEND, 32'hAE42_6082);
      if (kind == FILE_CUT) begin
        cut    = $urandom_range(1, file_q.size() - 1);
        file_q = file_q[0:cut-1];
      end
      counted = file_q.size();
      if (kind != FILE_CUT) begin
        repeat ($urandom_range(0, 3)) file_q.push_back('{8'($urandom), 1'b0});
      end
    end
  endtask

  // Stimulus
  initial begin
    int         items_sent;
    int         counted;
    int         file_idx;
    int         pick;
    file_kind_t kind;
    items_sent    = 0;
    file_idx      = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data_byte  <= 8'd0;
    in_file_start <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (STIM_TAB[i]) begin
      send_byte(STIM_TAB[i].data_byte, STIM_TAB[i].file_start,
                STIM_TAB[i].typed, STIM_TAB[i].res);
    end

    // Random files
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      kind = (file_idx == 0) ? FILE_HUGE :
             (pick < 80) ? FILE_CLEAN : (pick < 90) ? FILE_CUT :
             (pick < 96) ? FILE_HUGE : FILE_SPLICED;
      build_file(kind, counted);
      idle_on = !quiet && ($urandom_range(0, 3) != 0);
      if (file_idx == 1) long_hold_req = 1'b1;
      foreach (file_q[i]) send_byte(file_q[i].data_byte, file_q[i].file_start, 1'b0, NO_RES);
      items_sent += counted;
      file_idx++;
      if (items_sent >= ITEM_TARGET - CALM_ITEMS) quiet = 1'b1;
    end
    in_valid <= 1'b0;

    // Drain, then let the block idle on to show any misbehaviour
    while (chunk_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver: random short stalls, one long hold-off, none at the end
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD;
      end else if (stall_left == 0 && idle_on && !quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Check each out transaction against the oldest expected chunk
  always @(posedge clk) begin
    chunk_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (chunk_q.size() == 0) begin
        report_mismatch("unexpected chunk, type", out_chunk_type, 32'd0);
      end else begin
        want = chunk_q.pop_front();
        if (out_chunk_length !== want.length)
          report_mismatch("chunk_length", out_chunk_length, want.length);
        if (out_chunk_type !== want.ctype)
          report_mismatch("chunk_type", out_chunk_type, want.ctype);
        if (out_crc_value !== want.crc)
          report_mismatch("crc_value", out_crc_value, want.crc);
        if (out_end_of_image !== want.eoi)
          report_mismatch("end_of_image", {31'd0, out_end_of_image}, {31'd0, want.eoi});
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
src/pcw_pkg.sv
src/pcw_crc8.sv
src/pcw_in_stage.sv
src/pcw_parser.sv
src/png_chunk_walker_crc32.sv
tb/sv/png_chunk_walker_crc32_tb.sv
